>>> rtl/srg_pkg.sv
// Package for the subtractive random generator unit.
// Holds constants, the sequencer state type and the lag table port struct.
// No dependencies.
package srg_pkg;

  localparam int unsigned SampleW = 30;
  localparam int unsigned SeedW   = 24;
  localparam int unsigned AddrW   = 6;

  localparam logic [SampleW-1:0] Modulus  = 30'd1000000000;
  localparam logic [SampleW-1:0] SeedBase = 30'd161803398;
  localparam logic [SeedW-1:0]   SeedMax  = 24'd10000000;
  localparam logic [AddrW-1:0]   TableLen = 6'd55;
  localparam logic [AddrW-1:0]   FillStride = 6'd21;
  localparam logic [AddrW-1:0]   LagStart = 6'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_DRAW_RD,
    ST_DRAW_WR
  } srg_state_e;

  typedef struct packed {
    logic               we;
    logic [AddrW-1:0]   waddr;
    logic [SampleW-1:0] wdata;
    logic               re;
    logic [AddrW-1:0]   raddr_a;
    logic [AddrW-1:0]   raddr_b;
  } srg_ram_req_t;

endpackage

>>> rtl/srg_req_if.sv
// Request channel of the subtractive random generator unit.
// Carries valid, ready and the reseed flag. No dependencies.
interface srg_req_if;
  logic valid;
  logic ready;
  logic reseed;

  modport source (output valid, output reseed, input ready);
  modport sink   (input valid, input reseed, output ready);
endinterface

>>> rtl/srg_rsp_if.sv
// Result channel of the subtractive random generator unit.
// Carries valid, ready and the 30-bit sample. No dependencies.
interface srg_rsp_if;
  logic        valid;
  logic        ready;
  logic [29:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/srg_mod_sub.sv
// Shared modular subtract unit: (a - b) mod 10^9 for a, b below 10^9.
// Depends on srg_pkg.
module srg_mod_sub (
  input  logic [srg_pkg::SampleW-1:0] a_i,
  input  logic [srg_pkg::SampleW-1:0] b_i,
  output logic [srg_pkg::SampleW-1:0] diff_o
);
  import srg_pkg::*;

  logic [SampleW:0] wrap_sum;

  assign wrap_sum = {1'b0, a_i} + {1'b0, Modulus - b_i};
  assign diff_o   = (a_i >= b_i) ? (a_i - b_i) : wrap_sum[SampleW-1:0];

endmodule

>>> rtl/srg_lag_ram.sv
// 55-entry lag table: one write port, two registered read ports.
// Depends on srg_pkg.
module srg_lag_ram (
  input  logic                          clk_i,
  input  srg_pkg::srg_ram_req_t         req_i,
  output logic [srg_pkg::SampleW-1:0]   rdata_a_o,
  output logic [srg_pkg::SampleW-1:0]   rdata_b_o
);
  import srg_pkg::*;

  localparam int unsigned Depth = 55;

  logic [SampleW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_a_o <= mem[req_i.raddr_a];
      rdata_b_o <= mem[req_i.raddr_b];
    end
  end

endmodule

>>> rtl/subtractive_random_generator_unit.sv
// Subtractive lagged generator (modulus 10^9), top level.
// Draw: request accepted, table read, table write (held while the last sample waits), sample out;
// no new request until idle. Rebuild (first request or reseed): 55 fill steps, then 4 x 55
// scramble steps of table read and table write, then a draw; all serial on the shared subtractor and RAM.
// Reset (async, rst_ni low): seed 1, pointers 0/31, table marked not built; no clearing pass.
// Depends on srg_pkg, srg_req_if, srg_rsp_if, srg_mod_sub, srg_lag_ram.
module subtractive_random_generator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [srg_pkg::SeedW-1:0] cfg_wdata_i,
  srg_req_if.sink                   req_i,
  srg_rsp_if.source                 rsp_o
);
  import srg_pkg::*;

  srg_state_e state_q, state_d;

  logic [SeedW-1:0]   seed_q;
  logic [AddrW-1:0]   lead_q, lead_d;
  logic [AddrW-1:0]   lag_q, lag_d;
  logic               table_ready_q, table_ready_d;
  logic [SampleW-1:0] cur_q, cur_d;
  logic [SampleW-1:0] prev_q, prev_d;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [AddrW-1:0]   cnt_q, cnt_d;
  logic [1:0]         pass_q, pass_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic [SampleW-1:0] sample_q, sample_d;

  srg_ram_req_t       ram_req;
  logic [SampleW-1:0] rd_a, rd_b;
  logic [SampleW-1:0] sub_a, sub_b, sub_diff;
  logic [AddrW:0]     pos_sum;
  logic [AddrW-1:0]   partner;
  logic [AddrW-1:0]   lead_nxt, lag_nxt;
  logic               req_fire, out_blocked;

  srg_lag_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  srg_mod_sub u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff)
  );

  assign req_i.ready  = (state_q == ST_IDLE);
  assign req_fire     = req_i.valid && req_i.ready;
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.sample = sample_q;
  assign out_blocked  = rsp_valid_q && !rsp_o.ready;

  assign sub_a = (state_q == ST_FILL) ? cur_q  : rd_a;
  assign sub_b = (state_q == ST_FILL) ? prev_q : rd_b;

  assign pos_sum  = {1'b0, pos_q} + {1'b0, FillStride};
  assign partner  = (cnt_q <= (TableLen - LagStart)) ? (cnt_q + LagStart)
                                                     : (cnt_q - (TableLen - LagStart));
  assign lead_nxt = (lead_q == TableLen) ? 6'd1 : (lead_q + 6'd1);
  assign lag_nxt  = (lag_q == TableLen) ? 6'd1 : (lag_q + 6'd1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.reseed || !table_ready_q) ? ST_FILL : ST_DRAW_RD;
        end
      end
      ST_FILL: begin
        if (cnt_q == TableLen - 6'd1) state_d = ST_SCR_RD;
      end
      ST_SCR_RD: state_d = ST_SCR_WR;
      ST_SCR_WR: begin
        if (cnt_q == TableLen && pass_q == 2'd3) state_d = ST_DRAW_RD;
        else                                     state_d = ST_SCR_RD;
      end
      ST_DRAW_RD: state_d = ST_DRAW_WR;
      ST_DRAW_WR: begin
        if (!out_blocked) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and table port
  always_comb begin
    lead_d        = lead_q;
    lag_d         = lag_q;
    table_ready_d = table_ready_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    pass_d        = pass_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    sample_d      = sample_q;
    ram_req       = '0;
    case (state_q)
      ST_IDLE: begin
        cur_d  = SeedBase - {{(SampleW-SeedW){1'b0}}, seed_q};
        prev_d = 30'd1;
        pos_d  = FillStride;
        cnt_d  = '0;
      end
      ST_FILL: begin
        ram_req.we = 1'b1;
        if (cnt_q == '0) begin
          ram_req.waddr = TableLen - 6'd1;
          ram_req.wdata = cur_q;
        end else begin
          ram_req.waddr = pos_q - 6'd1;
          ram_req.wdata = prev_q;
          cur_d  = prev_q;
          prev_d = sub_diff;
          pos_d  = (pos_sum >= {1'b0, TableLen}) ? AddrW'(pos_sum - {1'b0, TableLen})
                                                 : pos_sum[AddrW-1:0];
        end
        if (cnt_q == TableLen - 6'd1) begin
          cnt_d  = 6'd1;
          pass_d = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_SCR_RD: begin
        ram_req.re      = 1'b1;
        ram_req.raddr_a = cnt_q - 6'd1;
        ram_req.raddr_b = partner - 6'd1;
      end
      ST_SCR_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_q - 6'd1;
        ram_req.wdata = sub_diff;
        if (cnt_q == TableLen) begin
          cnt_d  = 6'd1;
          pass_d = pass_q + 2'd1;
          if (pass_q == 2'd3) begin
            lead_d        = '0;
            lag_d         = LagStart;
            table_ready_d = 1'b1;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_DRAW_RD: begin
        lead_d          = lead_nxt;
        lag_d           = lag_nxt;
        ram_req.re      = 1'b1;
        ram_req.raddr_a = lead_nxt - 6'd1;
        ram_req.raddr_b = lag_nxt - 6'd1;
      end
      ST_DRAW_WR: begin
        if (!out_blocked) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = lead_q - 6'd1;
          ram_req.wdata = sub_diff;
          rsp_valid_d   = 1'b1;
          sample_d      = (sub_diff == '0) ? 30'd1 : sub_diff;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      seed_q        <= 24'd1;
      lead_q        <= '0;
      lag_q         <= LagStart;
      table_ready_q <= 1'b0;
      cnt_q         <= '0;
      pass_q        <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      lead_q        <= lead_d;
      lag_q         <= lag_d;
      table_ready_q <= table_ready_d;
      cnt_q         <= cnt_d;
      pass_q        <= pass_d;
      rsp_valid_q   <= rsp_valid_d;
      // out-of-range seeds are dropped
      if (cfg_we_i && cfg_wdata_i != '0 && cfg_wdata_i <= SeedMax) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    pos_q    <= pos_d;
    sample_q <= sample_d;
  end

  a_seed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_q != '0 && seed_q <= SeedMax)
    else $error("seed register out of range");

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (state_q == ST_FILL || state_q == ST_SCR_WR || state_q == ST_DRAW_WR))
    else $error("table write outside a write step");

  a_rsp_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == ST_DRAW_WR)
    else $error("result raised outside draw write");

  a_draw_needs_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAW_RD |-> table_ready_q)
    else $error("draw before table built");

  a_scr_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCR_RD || state_q == ST_SCR_WR) |-> (cnt_q != '0 && cnt_q <= TableLen))
    else $error("scramble index out of range");

endmodule

>>> verif/srg_sample_checker.sv
// Sample checker for the subtractive random generator unit.
// Watches config, request and result channels, predicts each sample and compares.
// Depends on srg_pkg.
module srg_sample_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [srg_pkg::SeedW-1:0]   cfg_wdata_i,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  logic                        req_reseed_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  logic [srg_pkg::SampleW-1:0] rsp_sample_i,
  output int                          pending_o,
  output int                          errors_o
);
  import srg_pkg::*;

  localparam int unsigned ModN       = Modulus;
  localparam int unsigned BaseN      = SeedBase;
  localparam int unsigned RingLen    = TableLen;
  localparam int unsigned StrideN    = FillStride;
  localparam int unsigned MateOffset = 30;

  logic [SampleW-1:0] lag_ring [RingLen];
  logic [SeedW-1:0]   seed_q     = SeedW'(1);
  int unsigned        lead_idx   = 0;
  int unsigned        lag_idx    = 32'(LagStart);
  bit                 ring_built = 1'b0;
  logic [SampleW-1:0] sample_q [$];
  logic [SampleW-1:0] want;
  int                 err_cnt    = 0;

  assign errors_o = err_cnt;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    err_cnt++;
  endtask

  function automatic int unsigned sub_mod(input int unsigned a, input int unsigned b);
    return (a >= b) ? a - b : a + ModN - b;
  endfunction

  function automatic int unsigned step_ptr(input int unsigned p);
    return (p >= RingLen) ? 1 : p + 1;
  endfunction

  // 21-stride fill, then four scrambling passes against the lag-31 partner
  function automatic void reload_ring();
    int unsigned cur, prev, nxt, pos;
    cur  = (BaseN - int'(seed_q)) % ModN;
    prev = 1;
    lag_ring[RingLen-1] = SampleW'(cur);
    for (int unsigned i = 1; i < RingLen; i++) begin
      pos = (StrideN * i) % RingLen;
      lag_ring[pos-1] = SampleW'(prev);
      nxt  = sub_mod(cur, prev);
      cur  = prev;
      prev = nxt;
    end
    repeat (4) begin
      for (int unsigned i = 1; i <= RingLen; i++) begin
        lag_ring[i-1] = SampleW'(sub_mod(32'(lag_ring[i-1]),
                                         32'(lag_ring[(i + MateOffset) % RingLen])));
      end
    end
    lead_idx   = 0;
    lag_idx    = 32'(LagStart);
    ring_built = 1'b1;
  endfunction

  function automatic logic [SampleW-1:0] next_sample(input logic reseed);
    int unsigned diff;
    if (reseed || !ring_built) reload_ring();
    lead_idx = step_ptr(lead_idx);
    lag_idx  = step_ptr(lag_idx);
    diff = sub_mod(32'(lag_ring[lead_idx-1]), 32'(lag_ring[lag_idx-1]));
    lag_ring[lead_idx-1] = SampleW'(diff);
    return (diff == 0) ? SampleW'(1) : SampleW'(diff);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     = SeedW'(1);
      lead_idx   = 0;
      lag_idx    = 32'(LagStart);
      ring_built = 1'b0;
      sample_q.delete();
      pending_o <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (sample_q.size() == 0) begin
          flag_mismatch($sformatf("sample %0d with no request outstanding", rsp_sample_i));
        end else begin
          want = sample_q.pop_front();
          if (rsp_sample_i !== want)
            flag_mismatch($sformatf("sample %0d, predicted %0d", rsp_sample_i, want));
        end
      end
      // out-of-range seeds are dropped by the block
      if (cfg_we_i && cfg_wdata_i >= 1 && cfg_wdata_i <= SeedMax) seed_q = cfg_wdata_i;
      if (req_valid_i && req_ready_i) sample_q.push_back(next_sample(req_reseed_i));
      pending_o <= sample_q.size();
    end
  end

endmodule

>>> verif/subtractive_random_generator_unit_tb.sv
// Testbench top for the subtractive random generator unit: clock, reset, seed writes,
// bursty requests and a stalling result sink; verdict from srg_sample_checker.
// Depends on srg_pkg, srg_req_if, srg_rsp_if, srg_sample_checker and the unit itself.
module subtractive_random_generator_unit_tb;
  import srg_pkg::*;

  localparam int RandomItems = 850;

  typedef enum {RX_OPEN, RX_LIGHT, RX_CYCLIC, RX_HEAVY} rx_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [SeedW-1:0] cfg_wdata_i;
  int               pending;
  int               errors;

  srg_req_if req_if ();
  srg_rsp_if rsp_if ();

  subtractive_random_generator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  srg_sample_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_reseed_i (req_if.reseed),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_sample_i (rsp_if.sample),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rx_mode_e rx_mode;
    int       tick;
    rsp_if.ready = 1'b0;
    rx_mode = RX_OPEN;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 48 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   rsp_if.ready <= 1'b1;
        RX_LIGHT:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
        RX_CYCLIC: rsp_if.ready <= (tick % 5 != 0) && (tick % 7 != 3);
        default:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // drop = lower valid after this request is taken
  task automatic send_request(input logic reseed, input bit drop);
    req_if.valid  <= 1'b1;
    req_if.reseed <= reseed;
    do @(posedge clk_i); while (!req_if.ready);
    if (drop) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_seed(input logic [SeedW-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_requests(input int count, input int reseed_odds);
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      for (int k = 0; k < burst; k++) begin
        send_request($urandom_range(1, reseed_odds) == 1,
                     (k == burst - 1) && (gap > 0 || burst == left));
      end
      left -= burst;
      if (gap > 1) repeat (gap - 1) @(posedge clk_i);
    end
  endtask

  initial begin
    int               sent, chunk;
    logic [SeedW-1:0] seed_val;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    req_if.valid  = 1'b0;
    req_if.reseed = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first request builds the table even without reseed; reset seed is the minimum
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    send_request(1'b1, 1'b1);
    write_seed(SeedMax);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    // out-of-range seeds must leave the register alone
    write_seed('0);
    send_request(1'b1, 1'b1);
    write_seed(SeedMax + SeedW'(1));
    write_seed('1);
    send_request(1'b1, 1'b1);
    send_request(1'b0, 1'b1);
    write_seed(SeedW'(1));
    send_request(1'b1, 1'b0);
    for (int k = 0; k < 8; k++) send_request(1'b0, k == 7);

    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 5))
        0:       seed_val = SeedMax;
        1:       seed_val = SeedW'(1);
        2:       seed_val = $urandom_range(0, 1) ? '0
                          : SeedW'($urandom_range(int'(SeedMax) + 1, 32'hFFFFFF));
        default: seed_val = SeedW'($urandom_range(1, int'(SeedMax)));
      endcase
      write_seed(seed_val);
      chunk = $urandom_range(40, 160);
      if (chunk > RandomItems - sent) chunk = RandomItems - sent;
      run_requests(chunk / 2, $urandom_range(4, 24));
      if (sent == 0 || $urandom_range(0, 2) == 0) wait_drained();
      run_requests(chunk - chunk / 2, $urandom_range(4, 24));
      sent += chunk;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
